### rtl/escaped_frame_receiver_top_macros.svh
// Assertion macros used by the escaped frame receiver controller.
`ifndef ESCAPED_FRAME_RECEIVER_TOP_MACROS_SVH
`define ESCAPED_FRAME_RECEIVER_TOP_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define EFR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define EFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/efr_pkg.sv
// Package with widths, register indexes and shared types of the escaped frame receiver.
package efr_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int BYTE_W           = 8;
  localparam int LEN_W            = 6;
  localparam int CFG_IDX_W        = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END    = 1'd1;

  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd92;
  localparam logic [BYTE_W-1:0] END_RESET    = 8'd69;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } efr_mem_ctl_t;

endpackage

### rtl/efr_store.sv
// Frame buffer memory with one write port and one registered read port.
module efr_store import efr_pkg::*; #(
  parameter int BufferDepth = BUFFER_DEPTH_DEF,
  localparam int AW = $clog2(BufferDepth)
) (
  input  logic              clk,
  input  efr_mem_ctl_t      mem_ctl,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [BufferDepth];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/efr_ctrl.sv
// Deframing control, configuration registers, readout sequencer and output register.
`include "escaped_frame_receiver_top_macros.svh"

module efr_ctrl import efr_pkg::*; #(
  parameter int BufferDepth = BUFFER_DEPTH_DEF,
  localparam int AW = $clog2(BufferDepth)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_payload_byte,
  output logic [BYTE_W-1:0]    out_frame_command,
  output logic [LEN_W-1:0]     out_frame_length,
  output logic                 out_is_empty,
  output logic                 out_is_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  output efr_mem_ctl_t         mem_ctl,
  output logic [AW-1:0]        wr_addr,
  output logic [BYTE_W-1:0]    wr_data,
  output logic [AW-1:0]        rd_addr,
  input  logic [BYTE_W-1:0]    rd_data
);

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_READ = 1'b1;
  localparam logic [AW-1:0] FILL_MAX = AW'(BufferDepth - 1);

  logic [0:0]        state_r, state_nxt;
  logic [BYTE_W-1:0] escape_byte_r, end_byte_r;
  logic              esc_pend_r, esc_pend_nxt;
  logic [AW-1:0]     fill_r, fill_nxt;
  logic [BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [AW-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic              rd_pend_r, pend_last_r, pend_empty_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_payload_r, out_cmd_r;
  logic [LEN_W-1:0]  out_len_r;
  logic              out_empty_r, out_last_r;
  logic              in_accept, out_accept, store_en, issue, issue_last, frame_empty;

  assign in_accept   = in_valid && !in_stall;
  assign out_accept  = out_valid_r && !out_stall;
  assign in_stall    = (state_r != S_IDLE);
  assign cfg_ready   = 1'b1;
  assign frame_empty = (fill_r == '0);
  assign issue       = (state_r == S_READ) && !rd_pend_r && (!out_valid_r || out_accept);
  assign issue_last  = frame_empty || (rd_cnt_r == fill_r - AW'(1));

  always_comb begin
    state_nxt    = state_r;
    esc_pend_nxt = esc_pend_r;
    fill_nxt     = fill_r;
    cmd_nxt      = cmd_r;
    rd_cnt_nxt   = rd_cnt_r;
    store_en     = 1'b0;
    if (in_accept) begin
      if (in_rx_byte == escape_byte_r) begin
        esc_pend_nxt = !esc_pend_r;
        store_en     = esc_pend_r;
      end else if (!esc_pend_r) begin
        store_en = 1'b1;
      end else begin
        esc_pend_nxt = 1'b0;
        if (in_rx_byte != end_byte_r) begin
          cmd_nxt  = in_rx_byte;
          fill_nxt = '0;
        end else begin
          rd_cnt_nxt = '0;
          state_nxt  = S_READ;
        end
      end
      if (store_en) begin
        fill_nxt = (fill_r == FILL_MAX) ? '0 : fill_r + AW'(1);
      end
    end
    if (issue) begin
      rd_cnt_nxt = rd_cnt_r + AW'(1);
      if (issue_last) begin
        state_nxt = S_IDLE;
      end
    end
  end

  assign mem_ctl.wr_en = store_en;
  assign mem_ctl.rd_en = issue;
  assign wr_addr       = fill_r;
  assign wr_data       = in_rx_byte;
  assign rd_addr       = rd_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      esc_pend_r    <= 1'b0;
      fill_r        <= '0;
      cmd_r         <= '0;
      rd_cnt_r      <= '0;
      rd_pend_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      escape_byte_r <= ESCAPE_RESET;
      end_byte_r    <= END_RESET;
    end else begin
      state_r    <= state_nxt;
      esc_pend_r <= esc_pend_nxt;
      fill_r     <= fill_nxt;
      cmd_r      <= cmd_nxt;
      rd_cnt_r   <= rd_cnt_nxt;
      rd_pend_r  <= issue;
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_accept) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ESCAPE: escape_byte_r <= cfg_data;
          CFG_END:    end_byte_r    <= cfg_data;
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_last_r  <= issue_last;
      pend_empty_r <= frame_empty;
    end
    if (rd_pend_r) begin
      out_payload_r <= pend_empty_r ? '0 : rd_data;
      out_cmd_r     <= cmd_r;
      out_len_r     <= LEN_W'(fill_r);
      out_empty_r   <= pend_empty_r;
      out_last_r    <= pend_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = out_payload_r;
  assign out_frame_command = out_cmd_r;
  assign out_frame_length  = out_len_r;
  assign out_is_empty      = out_empty_r;
  assign out_is_last       = out_last_r;

  `EFR_ASSERT_IMPL(a_load_free, rd_pend_r, !out_valid_r || out_accept, "Output register overwritten.")
  `EFR_ASSERT_IMPL(a_fill_range, 1'b1, fill_r <= FILL_MAX, "Fill count beyond buffer depth.")
  `EFR_ASSERT_NEXT(a_last_idle, issue && issue_last, state_r == S_IDLE, "Readout did not end.")
  `EFR_ASSERT_IMPL(a_empty_last, out_valid_r && out_empty_r, out_last_r, "Empty frame not last.")

endmodule

### rtl/escaped_frame_receiver_top.sv
// Top level of the escaped frame receiver: controller and frame buffer memory.
//
// Usage: raw received bytes enter on the in_ channel, one byte per beat. An
// escape byte followed by a byte other than escape or end starts a frame and
// sets its command; escape-escape stores an escape byte as data; escape-end
// completes the frame. Completed frames leave on the out_ channel, one beat per
// payload byte with command, length and last flag, or a single beat marked
// empty for a frame without payload.
// The cfg_ channel writes the escape byte (index 0) and the end byte (index 1);
// cfg_ready is always high.
// Throughput: one input byte per cycle while no frame is being read out. During
// readout in_stall is high and the next frame buffer read waits until the previous
// one has reached the one output register and that register is free or being taken.
// After the end byte, readout state, pending-read flag and output register set in turn.
// Reset clears the escape flag, fill count, command and readout state and
// restores the default escape and end bytes; buffer contents are not cleared.
// When out_stall is high the current result holds and readout pauses.
module escaped_frame_receiver_top import efr_pkg::*; #(
  parameter int BufferDepth = BUFFER_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_payload_byte,
  output logic [BYTE_W-1:0]    out_frame_command,
  output logic [LEN_W-1:0]     out_frame_length,
  output logic                 out_is_empty,
  output logic                 out_is_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  localparam int AW = $clog2(BufferDepth);

  efr_mem_ctl_t      mem_ctl;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [BYTE_W-1:0] wr_data, rd_data;

  efr_ctrl #(.BufferDepth(BufferDepth)) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_byte  (out_payload_byte),
    .out_frame_command (out_frame_command),
    .out_frame_length  (out_frame_length),
    .out_is_empty      (out_is_empty),
    .out_is_last       (out_is_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mem_ctl           (mem_ctl),
    .wr_addr           (wr_addr),
    .wr_data           (wr_data),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data)
  );

  efr_store #(.BufferDepth(BufferDepth)) u_store (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
